[rtl/peer_table_lru_aging_top_defines.svh]
// Assertion macros for the peer table block
`ifndef PEER_TABLE_LRU_AGING_TOP_DEFINES_SVH
`define PEER_TABLE_LRU_AGING_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PTLA_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PTLA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define PTLA_CHECK(lbl, prop, msg)
`define PTLA_NEVER(lbl, cond, msg)
`endif

`endif

[rtl/ptla_pkg.sv]
`default_nettype none
package ptla_pkg;

    localparam int ID_W    = 24;
    localparam int RSSI_W  = 9;
    localparam int TIME_W  = 32;
    localparam int CAPS_W  = 8;
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 6;
    localparam int CNT_W   = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_TOUCH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BEACON = 2'd1;
    localparam logic [CMD_W-1:0] CMD_AGE    = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_MY_LINK_ID = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_MS   = 1'd1;

    localparam logic [TIME_W-1:0] STALE_RESET = 32'd45000;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [RSSI_W-1:0] rssi;
        logic [TIME_W-1:0]        heard;
        logic [CAPS_W-1:0]        caps;
    } entry_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [ID_W-1:0]          link_id;
        logic signed [RSSI_W-1:0] rssi;
        logic [CAPS_W-1:0]        caps;
        logic [TIME_W-1:0]        now_ms;
        logic                     is_self;
    } item_t;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] count;
    } status_t;

endpackage
`default_nettype wire

[rtl/ptla_if.sv]
`default_nettype none
interface ptla_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [ptla_pkg::CMD_W-1:0]           cmd;
    logic [ptla_pkg::ID_W-1:0]            link_id;
    logic signed [ptla_pkg::RSSI_W-1:0]   rssi;
    logic [ptla_pkg::CAPS_W-1:0]          caps;
    logic [ptla_pkg::TIME_W-1:0]          now_ms;
    modport source (output valid, cmd, link_id, rssi, caps, now_ms, input ready);
    modport sink (input valid, cmd, link_id, rssi, caps, now_ms, output ready);
endinterface

interface ptla_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 found;
    logic                                 is_self;
    logic                                 evicted;
    logic [ptla_pkg::SLOT_W-1:0]          slot;
    logic signed [ptla_pkg::RSSI_W-1:0]   rssi_out;
    logic [ptla_pkg::CAPS_W-1:0]          caps_out;
    logic [ptla_pkg::CNT_W-1:0]           count;
    logic [ptla_pkg::CNT_W-1:0]           removed;
    modport source (output valid, found, is_self, evicted, slot, rssi_out, caps_out,
                    count, removed, input ready);
    modport sink (input valid, found, is_self, evicted, slot, rssi_out, caps_out,
                  count, removed, output ready);
endinterface

interface ptla_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [ptla_pkg::CFG_IDX_W-1:0]       index;
    logic [ptla_pkg::CFG_DATA_W-1:0]      data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/ptla_ram.sv]
`default_nettype none
module ptla_ram #(
    parameter int WIDTH = 73,
    parameter int DEPTH = 24,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

[rtl/ptla_front.sv]
`default_nettype none
module ptla_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    ptla_in_if.sink                    req,
    input  wire logic [ptla_pkg::ID_W-1:0] my_link_id,
    output logic                       q_valid,
    output ptla_pkg::item_t            q_item,
    input  wire logic                  q_pop
);
    import ptla_pkg::*;

    item_t      buf_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] fill_reg, fill_next;
    logic       push;
    item_t      cls;

    // classify own id once, at the door
    always_comb
    begin
        cls.cmd     = req.cmd;
        cls.link_id = req.link_id;
        cls.rssi    = req.rssi;
        cls.caps    = req.caps;
        cls.now_ms  = req.now_ms;
        cls.is_self = ((req.cmd == CMD_TOUCH) || (req.cmd == CMD_BEACON))
                      && (req.link_id == my_link_id);
    end

    assign req.ready = (fill_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign q_valid   = (fill_reg != 2'd0);
    assign q_item    = buf_reg[rp_reg];

    always_comb
    begin
        wp_next   = wp_reg ^ push;
        rp_next   = rp_reg ^ q_pop;
        fill_next = fill_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end
endmodule
`default_nettype wire

[rtl/ptla_back.sv]
`default_nettype none
module ptla_back #(
    parameter int MAX_PEERS = 24
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_valid,
    input  wire ptla_pkg::item_t         q_item,
    output logic                         q_pop,
    input  wire logic [ptla_pkg::TIME_W-1:0] stale_ms,
    ptla_out_if.source                   rsp,
    output ptla_pkg::status_t            status
);
    import ptla_pkg::*;

    localparam int AW = $clog2(MAX_PEERS);
    localparam int CW = $clog2(MAX_PEERS + 1);
    localparam logic [CW-1:0] FULL = CW'(MAX_PEERS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]    state_reg, state_next;
    item_t         it_reg, it_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] iss_reg, iss_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pidx_reg, pidx_next;
    logic [CW-1:0] w_reg, w_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic          fnd_reg, fnd_next;
    logic [AW-1:0] fslot_reg, fslot_next;
    logic signed [RSSI_W-1:0] frssi_reg, frssi_next;
    logic [CAPS_W-1:0] fcaps_reg, fcaps_next;
    logic [TIME_W-1:0] mint_reg, mint_next;
    logic [AW-1:0] mini_reg, mini_next;

    logic          rv_reg, rv_next;
    logic          r_found_reg, r_found_next;
    logic          r_self_reg, r_self_next;
    logic          r_evict_reg, r_evict_next;
    logic [SLOT_W-1:0] r_slot_reg, r_slot_next;
    logic signed [RSSI_W-1:0] r_rssi_reg, r_rssi_next;
    logic [CAPS_W-1:0] r_caps_reg, r_caps_next;
    logic [CNT_W-1:0] r_cnt_reg, r_cnt_next;
    logic [CNT_W-1:0] r_rem_reg, r_rem_next;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_ent;
    logic [$bits(entry_t)-1:0] rd_raw;
    entry_t        rd_ent;
    logic          stale;
    logic [AW-1:0] tslot;
    logic [CAPS_W-1:0] tcaps;

    ptla_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_PEERS)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_ent),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign rd_ent = entry_t'(rd_raw);
    assign stale  = (it_reg.now_ms - rd_ent.heard) > stale_ms;

    always_comb
    begin
        state_next = state_reg;
        it_next    = it_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        iss_next   = iss_reg;
        pend_next  = 1'b0;
        pidx_next  = pidx_reg;
        w_next     = w_reg;
        rem_next   = rem_reg;
        fnd_next   = fnd_reg;
        fslot_next = fslot_reg;
        frssi_next = frssi_reg;
        fcaps_next = fcaps_reg;
        mint_next  = mint_reg;
        mini_next  = mini_reg;
        rv_next      = rv_reg && !rsp.ready;
        r_found_next = r_found_reg;
        r_self_next  = r_self_reg;
        r_evict_next = r_evict_reg;
        r_slot_next  = r_slot_reg;
        r_rssi_next  = r_rssi_reg;
        r_caps_next  = r_caps_reg;
        r_cnt_next   = r_cnt_reg;
        r_rem_next   = r_rem_reg;
        q_pop   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = iss_reg[AW-1:0];
        wr_en   = 1'b0;
        wr_addr = w_reg[AW-1:0];
        wr_ent  = rd_ent;
        tslot   = fslot_reg;
        tcaps   = fcaps_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // hold off until the last result has gone
                if (q_valid && !rv_reg)
                begin
                    q_pop      = 1'b1;
                    it_next    = q_item;
                    n_next     = q_item.is_self ? '0 : cnt_reg;
                    iss_next   = '0;
                    w_next     = '0;
                    rem_next   = '0;
                    fnd_next   = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (iss_reg < n_reg)
                begin
                    rd_en     = 1'b1;
                    iss_next  = iss_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = iss_reg[AW-1:0];
                end
                else if (!pend_reg)
                begin
                    state_next = S_DONE;
                end
                if (pend_reg)
                begin
                    if (!fnd_reg && (rd_ent.id == it_reg.link_id))
                    begin
                        fnd_next   = 1'b1;
                        fslot_next = pidx_reg;
                        frssi_next = rd_ent.rssi;
                        fcaps_next = rd_ent.caps;
                    end
                    // stalest entry, lowest index on ties
                    if ((pidx_reg == '0) || (rd_ent.heard < mint_reg))
                    begin
                        mint_next = rd_ent.heard;
                        mini_next = pidx_reg;
                    end
                    if (it_reg.cmd == CMD_AGE)
                    begin
                        if (stale)
                        begin
                            rem_next = rem_reg + 1'b1;
                        end
                        else
                        begin
                            // compact: move survivor down to the write pointer
                            wr_en  = (w_reg != CW'(pidx_reg));
                            w_next = w_reg + 1'b1;
                        end
                    end
                end
            end
            S_DONE:
            begin
                rv_next      = 1'b1;
                r_found_next = 1'b0;
                r_self_next  = 1'b0;
                r_evict_next = 1'b0;
                r_slot_next  = '0;
                r_rssi_next  = '0;
                r_caps_next  = '0;
                r_rem_next   = '0;
                state_next   = S_IDLE;
                priority if (it_reg.cmd == CMD_AGE)
                begin
                    cnt_next   = w_reg;
                    r_rem_next = CNT_W'(rem_reg);
                end
                else if (it_reg.cmd == CMD_LOOKUP)
                begin
                    if (fnd_reg)
                    begin
                        r_found_next = 1'b1;
                        r_slot_next  = SLOT_W'(fslot_reg);
                        r_rssi_next  = frssi_reg;
                        r_caps_next  = fcaps_reg;
                    end
                end
                else if (it_reg.is_self)
                begin
                    r_self_next = 1'b1;
                end
                else
                begin
                    priority if (fnd_reg)
                    begin
                        tslot = fslot_reg;
                        tcaps = fcaps_reg;
                    end
                    else if (cnt_reg < FULL)
                    begin
                        tslot    = cnt_reg[AW-1:0];
                        tcaps    = '0;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        tslot        = mini_reg;
                        tcaps        = '0;
                        r_evict_next = 1'b1;
                    end
                    if (it_reg.cmd == CMD_BEACON)
                    begin
                        tcaps = it_reg.caps;
                    end
                    wr_en        = 1'b1;
                    wr_addr      = tslot;
                    wr_ent.id    = it_reg.link_id;
                    wr_ent.rssi  = it_reg.rssi;
                    wr_ent.heard = it_reg.now_ms;
                    wr_ent.caps  = tcaps;
                    r_found_next = fnd_reg;
                    r_slot_next  = SLOT_W'(tslot);
                    r_rssi_next  = it_reg.rssi;
                    r_caps_next  = tcaps;
                end
                r_cnt_next = CNT_W'(cnt_next);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        it_reg      <= it_next;
        n_reg       <= n_next;
        iss_reg     <= iss_next;
        pidx_reg    <= pidx_next;
        w_reg       <= w_next;
        rem_reg     <= rem_next;
        fnd_reg     <= fnd_next;
        fslot_reg   <= fslot_next;
        frssi_reg   <= frssi_next;
        fcaps_reg   <= fcaps_next;
        mint_reg    <= mint_next;
        mini_reg    <= mini_next;
        r_found_reg <= r_found_next;
        r_self_reg  <= r_self_next;
        r_evict_reg <= r_evict_next;
        r_slot_reg  <= r_slot_next;
        r_rssi_reg  <= r_rssi_next;
        r_caps_reg  <= r_caps_next;
        r_cnt_reg   <= r_cnt_next;
        r_rem_reg   <= r_rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            rv_reg    <= rv_next;
        end
    end

    assign rsp.valid    = rv_reg;
    assign rsp.found    = r_found_reg;
    assign rsp.is_self  = r_self_reg;
    assign rsp.evicted  = r_evict_reg;
    assign rsp.slot     = r_slot_reg;
    assign rsp.rssi_out = r_rssi_reg;
    assign rsp.caps_out = r_caps_reg;
    assign rsp.count    = r_cnt_reg;
    assign rsp.removed  = r_rem_reg;

    assign status.busy  = (state_reg != S_IDLE);
    assign status.count = CNT_W'(cnt_reg);
endmodule
`default_nettype wire

[rtl/peer_table_lru_aging_top.sv]
// Neighbour table of up to MAX_PEERS entries held in one single-port-read RAM.
// Items enter a two-deep queue; the back end then reads the table one entry a
// cycle, so an item's time grows with the number of entries, set by the
// sequential scan through the table RAM's one read port; own-id touches skip
// the scan. Results sit in an output register, and the next item starts once
// that register has been taken. Configuration writes are always ready and
// take effect at once.
`default_nettype none
`include "peer_table_lru_aging_top_defines.svh"
module peer_table_lru_aging_top #(
    parameter int MAX_PEERS = 24
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ptla_in_if.sink   req,
    ptla_out_if.source rsp,
    ptla_cfg_if.sink  cfg
);
    import ptla_pkg::*;

    logic [ID_W-1:0]   my_link_id_reg;
    logic [TIME_W-1:0] stale_ms_reg;
    logic              q_valid;
    item_t             q_item;
    logic              q_pop;
    status_t           status;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_link_id_reg <= '0;
            stale_ms_reg   <= STALE_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MY_LINK_ID: my_link_id_reg <= cfg.data[ID_W-1:0];
                REG_STALE_MS:   stale_ms_reg   <= cfg.data;
                default:        ;
            endcase
        end
    end

    ptla_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .my_link_id (my_link_id_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    ptla_back #(.MAX_PEERS(MAX_PEERS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .stale_ms (stale_ms_reg),
        .rsp      (rsp),
        .status   (status)
    );

    `PTLA_NEVER(a_count_bound, status.count > CNT_W'(MAX_PEERS), "entry count beyond table size")
    `PTLA_CHECK(a_evict_full, rsp.valid && rsp.evicted |-> rsp.count == CNT_W'(MAX_PEERS), "eviction with free room")
    `PTLA_CHECK(a_result_from_work, $rose(rsp.valid) |-> $past(status.busy), "result without work")
    `PTLA_CHECK(a_pop_needs_item, q_pop |-> q_valid, "queue popped while empty")
endmodule
`default_nettype wire

[dv/tb_peer_table_lru_aging_top.sv]
`default_nettype none
module tb_peer_table_lru_aging_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ptla_pkg::*;

    localparam int NPEERS = 24;

    typedef struct packed {
        logic             found;
        logic             is_self;
        logic             evicted;
        logic [SLOT_W-1:0] slot;
        logic [RSSI_W-1:0] rssi_out;
        logic [CAPS_W-1:0] caps_out;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  removed;
    } verdict_t;

    int mismatches = 0;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch: %s", what);
    endtask

    class peer_scoreboard;
        logic [ID_W-1:0]   own_id;
        logic [TIME_W-1:0] stale_limit;
        logic [ID_W-1:0]   ids[NPEERS];
        logic [RSSI_W-1:0] rssis[NPEERS];
        logic [TIME_W-1:0] heard[NPEERS];
        logic [CAPS_W-1:0] capss[NPEERS];
        int                live;
        verdict_t          pending[$];

        function new();
            own_id = '0;
            stale_limit = STALE_RESET;
            live = 0;
        endfunction

        function int find_peer(logic [ID_W-1:0] id);
            for (int i = 0; i < live; i++)
                if (ids[i] == id) return i;
            return -1;
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                   logic [RSSI_W-1:0] rssi, logic [CAPS_W-1:0] caps,
                                   logic [TIME_W-1:0] now);
            verdict_t v;
            int s;
            int w;
            v = '0;
            if (cmd == CMD_TOUCH || cmd == CMD_BEACON) begin
                if (id == own_id) v.is_self = 1'b1;
                else begin
                    s = find_peer(id);
                    if (s >= 0) begin
                        v.found = 1'b1;
                        rssis[s] = rssi;
                        heard[s] = now;
                    end else begin
                        if (live < NPEERS) begin
                            s = live;
                            live++;
                        end else begin
                            s = 0;
                            for (int i = 1; i < NPEERS; i++)
                                if (heard[i] < heard[s]) s = i;
                            v.evicted = 1'b1;
                        end
                        ids[s] = id;
                        rssis[s] = rssi;
                        heard[s] = now;
                        capss[s] = '0;
                    end
                    if (cmd == CMD_BEACON) capss[s] = caps;
                    v.slot = SLOT_W'(s);
                    v.rssi_out = rssis[s];
                    v.caps_out = capss[s];
                end
            end else if (cmd == CMD_AGE) begin
                w = 0;
                for (int r = 0; r < live; r++) begin
                    if (TIME_W'(now - heard[r]) > stale_limit) v.removed++;
                    else begin
                        ids[w] = ids[r];
                        rssis[w] = rssis[r];
                        heard[w] = heard[r];
                        capss[w] = capss[r];
                        w++;
                    end
                end
                live = w;
            end else begin
                s = find_peer(id);
                if (s >= 0) begin
                    v.found = 1'b1;
                    v.slot = SLOT_W'(s);
                    v.rssi_out = rssis[s];
                    v.caps_out = capss[s];
                end
            end
            v.count = CNT_W'(live);
            pending.push_back(v);
        endfunction

        task check_response(verdict_t got);
            verdict_t e;
            if (pending.size() == 0) begin
                report_mismatch("response with nothing outstanding");
                return;
            end
            e = pending.pop_front();
            if (got.found !== e.found) report_mismatch("found");
            if (got.is_self !== e.is_self) report_mismatch("is_self");
            if (got.evicted !== e.evicted) report_mismatch("evicted");
            if (got.slot !== e.slot) report_mismatch($sformatf("slot %0d/%0d", got.slot, e.slot));
            if (got.rssi_out !== e.rssi_out) report_mismatch("rssi_out");
            if (got.caps_out !== e.caps_out) report_mismatch("caps_out");
            if (got.count !== e.count)
                report_mismatch($sformatf("count %0d/%0d", got.count, e.count));
            if (got.removed !== e.removed)
                report_mismatch($sformatf("removed %0d/%0d", got.removed, e.removed));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ptla_in_if  req();
    ptla_out_if rsp();
    ptla_cfg_if cfg();

    peer_table_lru_aging_top #(.MAX_PEERS(NPEERS)) uut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
    );

    peer_scoreboard board = new();

    int send_idle = 0;   // percent
    int recv_stall = 0;  // percent
    bit hold_off = 1'b0;

    // id pool kept small so hits, evictions and refreshes are common
    logic [ID_W-1:0] id_pool[40];
    logic [TIME_W-1:0] clock_ms = 32'd1000;

    initial forever #5 clk = ~clk;

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        req.valid = 1'b0;
        req.cmd = CMD_LOOKUP;
        req.link_id = '0;
        req.rssi = '0;
        req.caps = '0;
        req.now_ms = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_MY_LINK_ID;
        cfg.data = '0;
    end

    // response side: random stall, plus a long hold-off when asked
    initial begin
        rsp.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp.valid && rsp.ready)
                board.check_response({rsp.found, rsp.is_self, rsp.evicted, rsp.slot,
                                      rsp.rssi_out, rsp.caps_out, rsp.count, rsp.removed});
            rsp.ready <= !hold_off && ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == REG_MY_LINK_ID) board.own_id = val[ID_W-1:0];
        else board.stale_limit = val;
        @(posedge clk);
    endtask

    // valid stays up after a beat; drop it only while idling
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id,
                                input logic [RSSI_W-1:0] rssi, input logic [CAPS_W-1:0] caps,
                                input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle) begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd <= cmd;
        req.link_id <= id;
        req.rssi <= rssi;
        req.caps <= caps;
        req.now_ms <= now;
        do @(posedge clk); while (!req.ready);
        board.note_request(cmd, id, rssi, caps, now);
    endtask

    task automatic drain;
        int guard;
        guard = 0;
        req.valid <= 1'b0;
        while (board.pending.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic random_request;
        int pick;
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0] id;
        pick = $urandom_range(99);
        if (pick < 40) cmd = CMD_TOUCH;
        else if (pick < 70) cmd = CMD_BEACON;
        else if (pick < 80) cmd = CMD_AGE;
        else cmd = CMD_LOOKUP;
        if ($urandom_range(9) == 0) id = ID_W'($urandom());
        else if ($urandom_range(19) == 0) id = board.own_id;
        else id = id_pool[$urandom_range(39)];
        // mostly advancing time, with the odd jump or step back
        pick = $urandom_range(99);
        if (pick < 85) clock_ms += $urandom_range(3000);
        else if (pick < 95) clock_ms += $urandom_range(60000);
        else clock_ms = $urandom();
        send_request(cmd, id, RSSI_W'($urandom()), CAPS_W'($urandom()), clock_ms);
    endtask

    task automatic run_phase(input int n, input int idle, input int stall);
        send_idle = idle;
        recv_stall = stall;
        repeat (n) random_request();
    endtask

    initial begin
        foreach (id_pool[i]) id_pool[i] = ID_W'($urandom());
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes and each special case
        send_request(CMD_LOOKUP, 24'h000001, '0, '0, '0);
        send_request(CMD_TOUCH, 24'h000000, 9'h0FF, 8'hFF, 32'd5); // own id at reset
        send_request(CMD_TOUCH, 24'hFFFFFF, 9'h100, 8'hFF, 32'hFFFF_FFFF);
        send_request(CMD_BEACON, 24'hFFFFFF, 9'h0FF, 8'hA5, 32'd10);
        send_request(CMD_BEACON, 24'h123456, 9'h1FF, 8'h5A, 32'd20);
        send_request(CMD_TOUCH, 24'h123456, 9'h000, 8'h00, 32'd30);
        send_request(CMD_LOOKUP, 24'h123456, '0, '0, '0);
        send_request(CMD_LOOKUP, 24'h000000, '0, '0, '0);
        send_request(CMD_AGE, '0, '0, '0, 32'd40000);      // both entries still within the stale limit
        for (int i = 0; i < NPEERS + 3; i++)
            send_request(i[0] ? CMD_BEACON : CMD_TOUCH, ID_W'(24'h400000 + i), 9'(i), 8'(i),
                         32'd50000 + (i % 5));
        send_request(CMD_AGE, '0, '0, '0, 32'd50002);
        drain();

        write_reg(REG_MY_LINK_ID, 32'h00FF_FFFF);
        write_reg(REG_STALE_MS, 32'd0);
        send_request(CMD_TOUCH, 24'hFFFFFF, 9'd3, '0, 32'd60000);
        send_request(CMD_AGE, '0, '0, '0, 32'd60000);
        run_phase(150, 0, 0);
        drain();

        write_reg(REG_STALE_MS, 32'hFFFF_FFFF);
        write_reg(REG_MY_LINK_ID, {8'd0, id_pool[0]});
        run_phase(250, 86, 0);
        drain();

        write_reg(REG_STALE_MS, STALE_RESET);
        write_reg(REG_MY_LINK_ID, 32'd0);
        run_phase(250, 0, 86);

        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            run_phase(20, 0, 0);
        join
        drain();

        write_reg(REG_STALE_MS, 32'd8000);
        run_phase(250, 17, 17);
        drain();

        write_reg(REG_MY_LINK_ID, {8'd0, id_pool[5]});
        write_reg(REG_STALE_MS, 32'd20000);
        run_phase(350, 0, 0);
        run_phase(350, 17, 17);
        drain();

        if (mismatches == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
